// File: rtl/core/cta_pkg.sv
// Shared types, op codes and width helpers for the typed integer ALU.
`timescale 1ns / 1ps
`default_nettype none
package cta_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned DivSteps = DataW;
  localparam logic [5:0] ShMask = 6'd63;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_AND = 5'd3, OP_OR = 5'd4,
    OP_XOR = 5'd5, OP_DIV = 5'd6, OP_REM = 5'd7, OP_LT = 5'd8, OP_GT = 5'd9,
    OP_LE = 5'd10, OP_GE = 5'd11, OP_EQ = 5'd12, OP_NE = 5'd13, OP_SHL = 5'd14,
    OP_SHR = 5'd15, OP_LAND = 5'd16, OP_LOR = 5'd17, OP_POS = 5'd18,
    OP_NEG = 5'd19, OP_NOT = 5'd20, OP_LNOT = 5'd21
  } op_t;

  typedef enum logic [1:0] {
    WC_8 = 2'd0, WC_16 = 2'd1, WC_32 = 2'd2, WC_64 = 2'd3
  } wcode_t;

  typedef enum logic [1:0] {
    SEL_PLAIN = 2'd0, SEL_MUL = 2'd1, SEL_DIV = 2'd2, SEL_REM = 2'd3
  } sel_t;

  // Result payload carried alongside the divider chain.
  typedef struct packed {
    logic [DataW-1:0] res;
    logic             w64;
    logic             u;
    logic             err;
    sel_t             sel;
    logic             qneg;
    logic             rneg;
  } pay_t;

  // One divider step state: partial remainder, dividend/quotient shifter, divisor.
  typedef struct packed {
    logic [DataW-1:0] r;
    logic [DataW-1:0] z;
    logic [DataW-1:0] d;
  } div_t;

  // Cut to 32 or 64 bits and extend back to 64.
  function automatic logic [DataW-1:0] fit32(input logic [DataW-1:0] v, input logic w64,
                                             input logic u);
    logic [DataW-1:0] o;
    if (w64)    o = v;
    else if (u) o = {32'd0, v[31:0]};
    else        o = {{32{v[31]}}, v[31:0]};
    return o;
  endfunction

  // Cut an operand to its own width and extend by its own signedness.
  function automatic logic [DataW-1:0] fit_in(input logic [DataW-1:0] v, input wcode_t c,
                                              input logic u);
    logic [DataW-1:0] o;
    case (c)
      WC_8:    o = u ? {56'd0, v[7:0]}  : {{56{v[7]}}, v[7:0]};
      WC_16:   o = u ? {48'd0, v[15:0]} : {{48{v[15]}}, v[15:0]};
      WC_32:   o = u ? {32'd0, v[31:0]} : {{32{v[31]}}, v[31:0]};
      default: o = v;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/cta_front.sv
// Operand decode, promotion, common type and all ops but multiply, divide and remainder, registered.
`timescale 1ns / 1ps
`default_nettype none
module cta_front (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [4:0]                 op,
  input  wire logic [cta_pkg::DataW-1:0]  a_value,
  input  wire logic [1:0]                 a_width_code,
  input  wire logic                       a_is_unsigned,
  input  wire logic [cta_pkg::DataW-1:0]  b_value,
  input  wire logic [1:0]                 b_width_code,
  input  wire logic                       b_is_unsigned,
  output cta_pkg::pay_t                   pay,
  output logic [cta_pkg::DataW-1:0]       x,
  output logic [cta_pkg::DataW-1:0]       y
);

  logic [cta_pkg::DataW-1:0] av, bv, xc, yc, cx, cy, shr_v;
  logic                      a64, b64, pau, pbu, cw64, cu;
  logic [5:0]                sh;
  cta_pkg::pay_t             pay_next;

  always_comb begin
    av  = cta_pkg::fit_in(a_value, cta_pkg::wcode_t'(a_width_code), a_is_unsigned);
    bv  = cta_pkg::fit_in(b_value, cta_pkg::wcode_t'(b_width_code), b_is_unsigned);
    a64 = (a_width_code == cta_pkg::WC_64);
    b64 = (b_width_code == cta_pkg::WC_64);
    // narrow types promote to signed 32
    pau = a_is_unsigned && (a_width_code[1] == 1'b1);
    pbu = b_is_unsigned && (b_width_code[1] == 1'b1);
    if (pau == pbu) begin
      cw64 = a64 | b64;
      cu   = pau;
    end else if (pau) begin
      cw64 = a64 | b64;
      cu   = a64 | !b64;
    end else begin
      cw64 = a64 | b64;
      cu   = b64 | !a64;
    end
    xc = (cu && !cw64) ? {32'd0, av[31:0]} : av;
    yc = (cu && !cw64) ? {32'd0, bv[31:0]} : bv;
    cx = cu ? xc : {~xc[63], xc[62:0]};
    cy = cu ? yc : {~yc[63], yc[62:0]};
    sh = bv[5:0] & cta_pkg::ShMask;
    shr_v = (pau || !av[63]) ? (av >> sh) : ~((~av) >> sh);

    pay_next      = '0;
    pay_next.w64  = cw64;
    pay_next.u    = cu;
    pay_next.sel  = cta_pkg::SEL_PLAIN;
    case (op)
      cta_pkg::OP_ADD: pay_next.res = xc + yc;
      cta_pkg::OP_SUB: pay_next.res = xc - yc;
      cta_pkg::OP_MUL: pay_next.sel = cta_pkg::SEL_MUL;
      cta_pkg::OP_AND: pay_next.res = xc & yc;
      cta_pkg::OP_OR:  pay_next.res = xc | yc;
      cta_pkg::OP_XOR: pay_next.res = xc ^ yc;
      cta_pkg::OP_DIV, cta_pkg::OP_REM: begin
        pay_next.sel  = (op == cta_pkg::OP_DIV) ? cta_pkg::SEL_DIV : cta_pkg::SEL_REM;
        pay_next.err  = (yc == '0);
        pay_next.qneg = !cu && (xc[63] != yc[63]);
        pay_next.rneg = !cu && xc[63];
      end
      cta_pkg::OP_LT, cta_pkg::OP_GT, cta_pkg::OP_LE,
      cta_pkg::OP_GE, cta_pkg::OP_EQ, cta_pkg::OP_NE: begin
        pay_next.w64 = 1'b0;
        pay_next.u   = 1'b0;
        case (op)
          cta_pkg::OP_LT: pay_next.res = {63'd0, cx < cy};
          cta_pkg::OP_GT: pay_next.res = {63'd0, cx > cy};
          cta_pkg::OP_LE: pay_next.res = {63'd0, cx <= cy};
          cta_pkg::OP_GE: pay_next.res = {63'd0, cx >= cy};
          cta_pkg::OP_EQ: pay_next.res = {63'd0, cx == cy};
          default:        pay_next.res = {63'd0, cx != cy};
        endcase
      end
      cta_pkg::OP_SHL, cta_pkg::OP_SHR: begin
        pay_next.w64 = a64;
        pay_next.u   = pau;
        pay_next.res = (op == cta_pkg::OP_SHL) ? (av << sh) : shr_v;
      end
      cta_pkg::OP_LAND, cta_pkg::OP_LOR: begin
        pay_next.w64 = 1'b0;
        pay_next.u   = 1'b0;
        pay_next.res = (op == cta_pkg::OP_LAND) ? {63'd0, (av != '0) && (bv != '0)}
                                                : {63'd0, (av != '0) || (bv != '0)};
      end
      cta_pkg::OP_POS, cta_pkg::OP_NEG, cta_pkg::OP_NOT, cta_pkg::OP_LNOT: begin
        pay_next.w64 = a64;
        pay_next.u   = pau;
        case (op)
          cta_pkg::OP_POS: pay_next.res = av;
          cta_pkg::OP_NEG: pay_next.res = '0 - av;
          cta_pkg::OP_NOT: pay_next.res = ~av;
          default: begin
            pay_next.w64 = 1'b0;
            pay_next.u   = 1'b0;
            pay_next.res = {63'd0, av == '0};
          end
        endcase
      end
      default: pay_next.err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay <= pay_next;
      x   <= xc;
      y   <= yc;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/cta_div_cell.sv
// One restoring division step; a row of these forms the divider chain.
`timescale 1ns / 1ps
`default_nettype none
module cta_div_cell (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire cta_pkg::div_t din,
  input  wire cta_pkg::pay_t pin,
  output cta_pkg::div_t      dout,
  output cta_pkg::pay_t      pout
);

  logic [cta_pkg::DataW:0] rr, diff;
  cta_pkg::div_t           d_next;

  always_comb begin
    rr     = {din.r, din.z[cta_pkg::DataW-1]};
    diff   = rr - {1'b0, din.d};
    d_next = din;
    if (!diff[cta_pkg::DataW]) begin
      d_next.r = diff[cta_pkg::DataW-1:0];
      d_next.z = {din.z[cta_pkg::DataW-2:0], 1'b1};
    end else begin
      d_next.r = rr[cta_pkg::DataW-1:0];
      d_next.z = {din.z[cta_pkg::DataW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= d_next;
      pout <= pin;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/c_typed_integer_alu_unit.sv
// Top level: typed integer ALU with C conversion rules, pipelined one beat per cycle unless the output stalls.
//
//  channel | dir | tdata fields (low bit first)
//  s_axis  | in  | op[4:0] a_value[68:5] a_width_code[70:69] a_is_unsigned[71]
//          |     | b_value[135:72] b_width_code[137:136] b_is_unsigned[138], zero pad
//  m_axis  | out | result_value[63:0] result_width_code[65:64]
//          |     | result_is_unsigned[66] error[67], zero pad
//
// One beat enters per cycle while the pipe advances; every beat passes these registered stages
// from input to output: decode, partial products, product sum, 64 division cells, output register.
// The whole pipe advances together; it holds only while the output beat waits.
// Reset clears the valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module c_typed_integer_alu_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [143:0] s_axis_tdata,   // op, a_value, a_width_code, a_is_unsigned,
                                            // b_value, b_width_code, b_is_unsigned
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata    // result_value, result_width_code,
                                            // result_is_unsigned, error
);

  localparam int unsigned NCell = cta_pkg::DivSteps;

  logic en;
  // valid bits: front, mul, sum, cells
  logic               v0, v1, v2;
  logic [NCell-1:0]   vc;

  cta_pkg::pay_t             p0, p1, p1m, p2;
  logic [63:0]               x0, y0;
  logic [63:0]               pp0;
  logic [31:0]               pp1, pp2;
  cta_pkg::div_t             d1, d2;
  cta_pkg::pay_t             pc [NCell];
  cta_pkg::div_t             dc [NCell];
  logic [63:0]               fin, ax, ay;
  cta_pkg::pay_t             pl;

  // advance the whole pipe unless the output beat is stalled
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  cta_front u_front (
    .clk           (clk),
    .en            (en),
    .op            (s_axis_tdata[4:0]),
    .a_value       (s_axis_tdata[68:5]),
    .a_width_code  (s_axis_tdata[70:69]),
    .a_is_unsigned (s_axis_tdata[71]),
    .b_value       (s_axis_tdata[135:72]),
    .b_width_code  (s_axis_tdata[137:136]),
    .b_is_unsigned (s_axis_tdata[138]),
    .pay           (p0),
    .x             (x0),
    .y             (y0)
  );

  // partial products of the low 64 product bits, plus divider operand magnitudes
  always_comb begin
    ax = (!p0.u && x0[63]) ? ('0 - x0) : x0;
    ay = (!p0.u && y0[63]) ? ('0 - y0) : y0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp0  <= 64'(x0[31:0]) * 64'(y0[31:0]);
      pp1  <= 32'(x0[31:0] * y0[63:32]);
      pp2  <= 32'(x0[63:32] * y0[31:0]);
      p1   <= p0;
      d1   <= {{cta_pkg::DataW{1'b0}}, ax, ay};
    end
  end

  // sum partial products into the carried result
  always_comb begin
    p1m = p1;
    if (p1.sel == cta_pkg::SEL_MUL) p1m.res = pp0 + {pp1 + pp2, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2 <= p1m;
      d2 <= d1;
    end
  end

  for (genvar i = 0; i < NCell; i++) begin : g_cell
    if (i == 0) begin : g_first
      cta_div_cell u_cell (.clk(clk), .en(en), .din(d2), .pin(p2),
                           .dout(dc[i]), .pout(pc[i]));
    end else begin : g_next
      cta_div_cell u_cell (.clk(clk), .en(en), .din(dc[i-1]), .pin(pc[i-1]),
                           .dout(dc[i]), .pout(pc[i]));
    end
  end

  // sign fix for division, then cut to the result width
  always_comb begin
    pl = pc[NCell-1];
    case (pl.sel)
      cta_pkg::SEL_DIV: fin = pl.qneg ? ('0 - dc[NCell-1].z) : dc[NCell-1].z;
      cta_pkg::SEL_REM: fin = pl.rneg ? ('0 - dc[NCell-1].r) : dc[NCell-1].r;
      default:          fin = pl.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      vc <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
      vc <= {vc[NCell-2:0], v2};
      m_axis_tvalid <= vc[NCell-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pl.err) begin
        m_axis_tdata <= {4'd0, 1'b1, 1'b0, cta_pkg::WC_32, 64'd0};
      end else begin
        m_axis_tdata <= {4'd0, 1'b0, pl.u, (pl.w64 ? cta_pkg::WC_64 : cta_pkg::WC_32),
                         cta_pkg::fit32(fin, pl.w64, pl.u)};
      end
    end
  end

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[67] |-> (m_axis_tdata[63:0] == 64'd0)
      && (m_axis_tdata[65:64] == cta_pkg::WC_32) && !m_axis_tdata[66])
    else $error("error beat carries nonzero result fields");

  a_width: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[65:64] == cta_pkg::WC_32)
      || (m_axis_tdata[65:64] == cta_pkg::WC_64))
    else $error("result width code out of range");

  a_narrow_ext: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[65:64] == cta_pkg::WC_32) && !m_axis_tdata[66]
      |-> (m_axis_tdata[63:32] == {32{m_axis_tdata[31]}}))
    else $error("signed 32-bit result not sign extended");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vc) && $stable(v0))
    else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire

// File: bench/tb_c_typed_integer_alu_unit.sv
// Self-checking bench for the typed integer ALU: random and directed beats, scoreboard compare.
`timescale 1ns / 1ps
`default_nettype none
module tb_c_typed_integer_alu_unit;

  localparam int Latency = 68;
  localparam int StallLimit = 20000;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  wcode;
    logic        uns;
    logic        err;
  } alu_result_t;

  // Sign-extend or zero-extend the low w bits of v.
  function automatic logic [63:0] cut_ext(logic [63:0] v, int w, logic u);
    logic [63:0] m;
    m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    v = v & m;
    if (!u && w < 64 && v[w-1]) v = v | ~m;
    return v;
  endfunction

  // Predict one ALU result from the operator and its two typed operands.
  function automatic alu_result_t alu_predict(logic [4:0] op, logic [63:0] av, logic [1:0] ac,
                                              logic au, logic [63:0] bv, logic [1:0] bc,
                                              logic bu);
    alu_result_t r;
    int aw, bw, w;
    logic u;
    logic [63:0] x, y, q, m, ax, ay, res;
    logic nx, ny, c;
    aw = 8 << ac;
    bw = 8 << bc;
    x = cut_ext(av, aw, au);
    y = cut_ext(bv, bw, bu);
    r.value = 64'd0; r.wcode = cta_pkg::WC_32; r.uns = 1'b0; r.err = 1'b0;
    if (op == cta_pkg::OP_LAND || op == cta_pkg::OP_LOR) begin
      r.value = (op == cta_pkg::OP_LAND) ? 64'((x != 0) && (y != 0))
                                         : 64'((x != 0) || (y != 0));
      return r;
    end
    // promote narrow operands to signed 32
    if (aw < 32) begin aw = 32; au = 1'b0; x = cut_ext(x, 32, 1'b0); end
    if (bw < 32) begin bw = 32; bu = 1'b0; y = cut_ext(y, 32, 1'b0); end
    if (op >= cta_pkg::OP_POS && op <= cta_pkg::OP_LNOT) begin
      w = aw; u = au;
      case (op)
        cta_pkg::OP_POS: res = x;
        cta_pkg::OP_NEG: res = 64'd0 - x;
        cta_pkg::OP_NOT: res = ~x;
        default: begin r.value = 64'(x == 0); return r; end
      endcase
    end else if (op == cta_pkg::OP_SHL || op == cta_pkg::OP_SHR) begin
      w = aw; u = au;
      if (op == cta_pkg::OP_SHL) res = x << y[5:0];
      else if (au) res = x >> y[5:0];
      else res = $unsigned($signed(x) >>> y[5:0]);
    end else if (op <= cta_pkg::OP_NE) begin
      if (au == bu) begin
        w = (aw > bw) ? aw : bw; u = au;
      end else if ((au ? aw : bw) >= (au ? bw : aw)) begin
        w = au ? aw : bw; u = 1'b1;
      end else begin
        w = au ? bw : aw; u = 1'b0;
      end
      if (u) begin x = cut_ext(x, w, 1'b1); y = cut_ext(y, w, 1'b1); end
      case (op)
        cta_pkg::OP_ADD: res = x + y;
        cta_pkg::OP_SUB: res = x - y;
        cta_pkg::OP_MUL: res = x * y;
        cta_pkg::OP_AND: res = x & y;
        cta_pkg::OP_OR:  res = x | y;
        cta_pkg::OP_XOR: res = x ^ y;
        cta_pkg::OP_DIV, cta_pkg::OP_REM: begin
          if (y == 0) begin r.err = 1'b1; return r; end
          if (u) res = (op == cta_pkg::OP_DIV) ? x / y : x % y;
          else begin
            nx = x[63]; ny = y[63];
            ax = nx ? -x : x; ay = ny ? -y : y;
            q = ax / ay; m = ax % ay;
            if (nx != ny) q = -q;
            if (nx) m = -m;
            res = (op == cta_pkg::OP_DIV) ? q : m;
          end
        end
        default: begin
          if (!u) begin x[63] = ~x[63]; y[63] = ~y[63]; end
          case (op)
            cta_pkg::OP_LT: c = x < y;
            cta_pkg::OP_GT: c = x > y;
            cta_pkg::OP_LE: c = x <= y;
            cta_pkg::OP_GE: c = x >= y;
            cta_pkg::OP_EQ: c = x == y;
            default:        c = x != y;
          endcase
          r.value = 64'(c);
          return r;
        end
      endcase
    end else begin
      // unknown op codes flag an error with fixed result fields
      r.err = 1'b1;
      return r;
    end
    r.value = cut_ext(res, w, u);
    r.wcode = (w >= 64) ? cta_pkg::WC_64 : cta_pkg::WC_32;
    r.uns = u;
    return r;
  endfunction

  class alu_scoreboard;
    alu_result_t pending[$];
    int mismatches;

    function void note_input(logic [143:0] d);
      pending.push_back(alu_predict(d[4:0], d[68:5], d[70:69], d[71],
                                    d[135:72], d[137:136], d[138]));
    endfunction

    function void check_result(logic [71:0] d);
      alu_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[63:0] !== e.value || d[65:64] !== e.wcode || d[66] !== e.uns ||
          d[67] !== e.err || d[71:68] !== 4'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected value=%h w=%0d u=%0d err=%0d, ",
                    "got value=%h w=%0d u=%0d err=%0d"},
                   e.value, e.wcode, e.uns, e.err, d[63:0], d[65:64], d[66], d[67]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  alu_scoreboard sb = new();
  bit hold_sink = 1'b0;
  bit timed_out = 1'b0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  c_typed_integer_alu_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  // Note accepted beats on both sides at each rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (idle_cycles >= StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random ready, with one long hold-off requested by the sender.
  initial begin
    int g;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000;
      3: v = 64'h7fff_ffff_ffff_ffff;
      4: v = 64'($urandom_range(0, 9));
      5: v = -64'($urandom_range(1, 9));
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  // Offer one beat and hold it until accepted.
  task automatic send_beat(logic [4:0] op, logic [63:0] av, logic [1:0] ac, logic au,
                           logic [63:0] bv, logic [1:0] bc, logic bu, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, bu, bc, bv, au, ac, av, op};
    @(posedge clk iff s_axis_tready);
  endtask

  task automatic send_random(bit gaps);
    logic [4:0] op;
    op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(22, 31)) : 5'($urandom_range(0, 21));
    send_beat(op, rand_operand(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              rand_operand(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), gaps);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats: every op, extremes, signed min by -1, divide by zero,
    // stray upper bits, wide shift counts, mixed signedness.
    for (int k = 0; k < 22; k++)
      send_beat(5'(k), 64'hffff_ffff_ffff_ff85, cta_pkg::WC_8, 1'b0,
                64'hffff_ffff_0000_0003, cta_pkg::WC_32, k[0], 1'b0);
    send_beat(cta_pkg::OP_DIV, 64'h8000_0000_0000_0000, cta_pkg::WC_64, 1'b0,
              '1, cta_pkg::WC_64, 1'b0, 1'b0);
    send_beat(cta_pkg::OP_REM, 64'hffff_ffff_8000_0000, cta_pkg::WC_32, 1'b0,
              '1, cta_pkg::WC_8, 1'b0, 1'b0);
    send_beat(cta_pkg::OP_DIV, 64'd7, cta_pkg::WC_16, 1'b1,
              64'h100, cta_pkg::WC_8, 1'b1, 1'b0);
    send_beat(cta_pkg::OP_SHR, 64'h8000_0000_0000_0000, cta_pkg::WC_64, 1'b0,
              64'hff, cta_pkg::WC_8, 1'b1, 1'b0);
    send_beat(cta_pkg::OP_LT, '1, cta_pkg::WC_32, 1'b0, 64'd0, cta_pkg::WC_32, 1'b1, 1'b0);
    send_beat(5'd31, '1, cta_pkg::WC_64, 1'b1, '1, cta_pkg::WC_64, 1'b1, 1'b0);

    for (int i = 0; i < 800; i++) begin
      if (i == 200) begin
        // pause the sender until all results are back
        s_axis_tvalid <= 1'b0;
        wait (sb.pending.size() == 0);
        @(posedge clk);
      end
      if (i == 400) hold_sink = 1'b1;
      // stretches without gaps so the pipe fills and back-pressure shows
      send_random(!(i >= 400 && i < 500) && !(i >= 600 && i < 650));
    end
    s_axis_tvalid <= 1'b0;

    wait (sb.pending.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// File: c_typed_integer_alu_unit.f
rtl/core/cta_pkg.sv
rtl/core/cta_front.sv
rtl/core/cta_div_cell.sv
rtl/core/c_typed_integer_alu_unit.sv
bench/tb_c_typed_integer_alu_unit.sv
